// ===== hdl/bnt_pkg.sv =====
// shared types and constants for the neighbor table
`timescale 1ns / 1ps
`default_nettype none

package bnt_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ETX_PENALTY   = 2'd0,
        REG_RATE_FACTOR   = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } cfg_index_t;

    localparam logic       KIND_BEACON       = 1'b0;
    localparam logic       KIND_TICK         = 1'b1;
    localparam logic [7:0]  ETX_RESET         = 8'd1;
    localparam logic [7:0]  RATE_RESET        = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd1280;

    typedef struct packed {
        logic        kind;
        logic [15:0] sender_addr;
        logic [7:0]  sender_queue;
        logic [7:0]  local_queue;
    } item_t;

    typedef struct packed {
        logic        hop_found;
        logic [15:0] hop_addr;
        logic [15:0] hop_weight;
        logic        table_full;
    } result_t;

    // item and settings broadcast to every cell while a beat is in flight
    typedef struct packed {
        logic        kind;
        logic        any_match;
        logic [7:0]  sender_queue;
        logic [7:0]  local_queue;
        logic [7:0]  etx;
        logic [7:0]  rate;
        logic [15:0] timeout;
    } cmd_t;

    // wavefront passed from cell to cell
    typedef struct packed {
        logic        active;
        logic        ins;
        logic        found;
        logic [15:0] weight;
    } wave_t;

endpackage

`default_nettype wire

// ===== hdl/bnt_cell.sv =====
// one neighbor table entry with its slice of the best hop search
`timescale 1ns / 1ps
`default_nettype none

module bnt_cell #(
    parameter int ADDR_BITS = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  bnt_pkg::cmd_t         cmd,
    input  wire [ADDR_BITS-1:0]   cmd_addr,
    input  wire [ADDR_BITS-1:0]   probe_addr,
    output logic                  hit,
    input  bnt_pkg::wave_t        wave_in,
    input  wire [ADDR_BITS-1:0]   wave_addr_in,
    output bnt_pkg::wave_t        wave_out,
    output logic [ADDR_BITS-1:0]  wave_addr_out
);
    import bnt_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [7:0]           queue_reg;
    logic [7:0]           queue_next;
    logic [15:0]          timer_reg;
    logic [15:0]          timer_next;
    logic                 ins_next;
    logic [9:0]           diff;
    logic                 diff_pos;
    logic [15:0]          weight;
    logic                 better;
    wave_t                wave_reg;
    wave_t                wave_next;
    logic [ADDR_BITS-1:0] wave_addr_reg;
    logic [ADDR_BITS-1:0] wave_addr_next;

    assign hit = valid_reg && (addr_reg == probe_addr);

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        queue_next = queue_reg;
        timer_next = timer_reg;
        ins_next   = wave_in.ins;
        if (wave_in.active)
        begin
            if (cmd.kind == KIND_TICK)
            begin
                if (valid_reg)
                begin
                    if (timer_reg <= 16'd1)
                    begin
                        valid_next = 1'b0;
                        timer_next = 16'd0;
                    end
                    else
                    begin
                        timer_next = timer_reg - 16'd1;
                    end
                end
            end
            else if (cmd.any_match)
            begin
                if (valid_reg && (addr_reg == cmd_addr))
                begin
                    queue_next = cmd.sender_queue;
                    timer_next = cmd.timeout;
                end
            end
            else if (wave_in.ins && !valid_reg)
            begin
                // lowest free entry takes the new neighbor and ends the token
                valid_next = 1'b1;
                addr_next  = cmd_addr;
                queue_next = cmd.sender_queue;
                timer_next = cmd.timeout;
                ins_next   = 1'b0;
            end
        end
    end

    // weight from the entry as it stands after this beat's update
    always_comb
    begin
        diff     = {2'b00, cmd.local_queue} - {2'b00, queue_next} - {2'b00, cmd.etx};
        diff_pos = !diff[9] && (diff != 10'd0);
        weight   = diff[7:0] * cmd.rate;
        better   = valid_next && diff_pos && (weight > wave_in.weight);

        wave_next.active = wave_in.active;
        wave_next.ins    = ins_next;
        wave_next.found  = wave_in.found || better;
        wave_next.weight = better ? weight : wave_in.weight;
        wave_addr_next   = better ? addr_next : wave_addr_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        queue_reg     <= queue_next;
        timer_reg     <= timer_next;
        wave_addr_reg <= wave_addr_next;
    end

    assign wave_out      = wave_reg;
    assign wave_addr_out = wave_addr_reg;

endmodule

`default_nettype wire

// ===== hdl/backpressure_neighbor_table_unit.sv =====
// neighbor table with next hop selection, top level
//
// usage: raise start with an item while busy is low; the beat is taken at
// that edge and busy stays high until the result has been shown. an item is
// a beacon (kind 0) that refreshes or adds a neighbor, or a timer tick
// (kind 1) that ages every entry. each item gives exactly one result on
// result, marked by done for a single cycle; the receiver cannot stall it.
// timing: a wavefront enters cell 0 in the cycle right after the accept edge
// and moves one cell per cycle along the row of TABLE_DEPTH cells, updating
// the entry and carrying the best hop so far. done rises as the wave leaves
// the last cell and the result beat is taken at the next edge, where busy
// falls; the next item is taken only after that, so a new item never enters
// the row before the previous one is through.
// config: cfg_we with cfg_index and cfg_data writes a register at once;
// the user must write only while the block is idle; the block does not enforce it.
// reset: all entries free, registers at their default values.
`timescale 1ns / 1ps
`default_nettype none

module backpressure_neighbor_table_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_BITS   = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  bnt_pkg::item_t                        item,
    output logic                                  done,
    output bnt_pkg::result_t                      result,
    input  wire                                   cfg_we,
    input  wire [bnt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire [bnt_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import bnt_pkg::*;

    logic [7:0]           etx_reg;
    logic [7:0]           rate_reg;
    logic [15:0]          timeout_reg;
    logic                 busy_reg;
    logic                 launch_reg;
    cmd_t                 cmd_reg;
    logic [ADDR_BITS-1:0] cmd_addr_reg;
    logic                 accept;
    logic [ADDR_BITS+15:0] in_addr_ext;
    logic [ADDR_BITS-1:0] in_addr;
    logic [TABLE_DEPTH-1:0] hits;
    wave_t                wave_chain [TABLE_DEPTH+1];
    logic [ADDR_BITS-1:0] addr_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] active_vec;
    logic [ADDR_BITS+15:0] hop_addr_ext;

    assign accept      = start && !busy_reg;
    assign in_addr_ext = {{ADDR_BITS{1'b0}}, item.sender_addr};
    assign in_addr     = in_addr_ext[ADDR_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            etx_reg     <= ETX_RESET;
            rate_reg    <= RATE_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ETX_PENALTY:   etx_reg     <= cfg_data[7:0];
                REG_RATE_FACTOR:   rate_reg    <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
        end
    end

    // match is resolved over the whole table before the wave starts
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.kind         <= item.kind;
            cmd_reg.any_match    <= |hits;
            cmd_reg.sender_queue <= item.sender_queue;
            cmd_reg.local_queue  <= item.local_queue;
            cmd_reg.etx          <= etx_reg;
            cmd_reg.rate         <= rate_reg;
            cmd_reg.timeout      <= timeout_reg;
            cmd_addr_reg         <= in_addr;
        end
    end

    always_comb
    begin
        wave_chain[0].active = launch_reg;
        wave_chain[0].ins    = (cmd_reg.kind == KIND_BEACON) && !cmd_reg.any_match;
        wave_chain[0].found  = 1'b0;
        wave_chain[0].weight = 16'd0;
        addr_chain[0]        = '0;
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        bnt_cell #(
            .ADDR_BITS(ADDR_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd_reg),
            .cmd_addr     (cmd_addr_reg),
            .probe_addr   (in_addr),
            .hit          (hits[k]),
            .wave_in      (wave_chain[k]),
            .wave_addr_in (addr_chain[k]),
            .wave_out     (wave_chain[k+1]),
            .wave_addr_out(addr_chain[k+1])
        );
    end

    for (genvar k = 0; k <= TABLE_DEPTH; k++)
    begin : g_active
        assign active_vec[k] = wave_chain[k].active;
    end

    assign busy = busy_reg;
    assign done = wave_chain[TABLE_DEPTH].active;

    assign hop_addr_ext      = {16'd0, addr_chain[TABLE_DEPTH]};
    assign result.hop_found  = wave_chain[TABLE_DEPTH].found;
    assign result.hop_addr   = wave_chain[TABLE_DEPTH].found ? hop_addr_ext[15:0] : 16'd0;
    assign result.hop_weight = wave_chain[TABLE_DEPTH].weight;
    // token that reaches the end of the row found no free entry
    assign result.table_full = wave_chain[TABLE_DEPTH].ins;

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("result beat outside a busy period");

    a_launch_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> launch_reg)
        else $error("accepted item did not launch a wave");

    a_single_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_vec))
        else $error("more than one wave in the cell row");

    a_full_only_on_beacon: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (cmd_reg.kind == KIND_BEACON && !cmd_reg.any_match))
        else $error("table full flagged without a new neighbor beacon");

endmodule

`default_nettype wire
